// ===== hdl/pqh_pkg.sv =====
// shared types, codes and compare function for the heap priority queue
// no dependencies
package pqh_pkg;

  // widest level offset for the largest supported capacity
  localparam int unsigned OFF_W = 10;
  localparam int unsigned VAL_W = 32;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic TOK_UP = 1'b0;
  localparam logic TOK_DN = 1'b1;

  localparam logic [VAL_W-1:0] HEAD_EMPTY = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic [OFF_W-1:0] off;
  } pqh_tok_t;

  typedef struct packed {
    logic             valid;
    logic [OFF_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } pqh_wr_t;

  typedef struct packed {
    logic             valid;
    logic [OFF_W-1:0] addr;
  } pqh_rd_t;

  function automatic logic ranks_above(input logic mf, input logic [VAL_W-1:0] a,
                                       input logic [VAL_W-1:0] b);
    logic gt;
    logic lt;
    gt = $signed(a) > $signed(b);
    lt = $signed(a) < $signed(b);
    return mf ? gt : lt;
  endfunction

endpackage

// ===== hdl/priority_queue_heap_core.sv =====
// top level of the heap priority queue: request control, level cell chain, result register
// depends on pqh_pkg and pqh_cell
//
// Bounded priority queue of signed 32-bit words kept as a binary heap, one cell per heap
// level, each cell holding that level in a small local store. A push climbs from the new
// leaf towards the root and a pop moves the last entry to the root and sinks it; in both
// cases the entry travels one level per cycle (the cell registers the entry together with
// the read of its level store, then compares and writes to the neighbouring cell in the
// next cycle). A push into a non-empty queue sifts up before the head is read back; a pop
// that leaves entries behind first fetches the last entry, then sinks it; a rejected
// request, a push into an empty queue or a pop that empties it goes straight to the head
// read. One request is in flight at a time; a new one is taken while the previous result
// waits on the output. The mode bit is meant to be written only while idle, so that it
// steers only later sifting; the block itself does not enforce this. The level stores are
// not cleared after reset: only entries below the held count are ever read.
module priority_queue_heap_core import pqh_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // max_first
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // push_value[31:0]
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // head_value[31:0], entry_count[38:32], is_empty[39],
                                      // rejected[40], zero fill
);

  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned LEVELS = CW;
  localparam int unsigned LW     = $clog2(LEVELS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_HEAD  = 3'd3;
  localparam logic [2:0] ST_HEADW = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             mf_q;
  logic             rej_q, rej_d;
  logic [LW-1:0]    lvl_q, lvl_d;
  logic [VAL_W-1:0] pend_q;
  logic             out_valid_q;
  logic [47:0]      out_q;

  logic             acc, is_pop, full, empty, out_free;
  logic [CW-1:0]    j, oj;
  logic [LW-1:0]    jl, ilvl, flvl;
  logic [OFF_W-1:0] joff;
  pqh_tok_t         up_inj, dn_inj;
  pqh_wr_t          wr0;
  pqh_rd_t          fetch;

  pqh_tok_t         up_w   [LEVELS];
  pqh_tok_t         dn_w   [LEVELS];
  pqh_wr_t          wdn_w  [LEVELS];
  pqh_wr_t          wup_w  [LEVELS];
  logic [VAL_W-1:0] rd_w   [LEVELS];
  logic [LEVELS-1:0] done_w;

  function automatic logic [LW-1:0] lvl_of(input logic [CW-1:0] x);
    logic [LW-1:0] l;
    l = '0;
    for (int i = 0; i < CW; i++) begin
      if (x[i]) begin
        l = LW'(i);
      end
    end
    return l;
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid & s_axis_tready;
  assign is_pop        = (s_axis_tuser == REQ_POP);
  assign full          = (count_q == CW'(CAPACITY));
  assign empty         = (count_q == '0);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    j      = is_pop ? count_q : CW'(count_q + CW'(1));
    jl     = lvl_of(j);
    oj     = j;
    oj[jl] = 1'b0;
    joff   = OFF_W'(oj);
    ilvl   = jl - LW'(1);
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rej_d   = rej_q;
    lvl_d   = lvl_q;
    up_inj  = '0;
    dn_inj  = '0;
    wr0     = '0;
    fetch   = '0;
    flvl    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          rej_d = 1'b0;
          lvl_d = jl;
          if (!is_pop) begin
            if (full) begin
              rej_d   = 1'b1;
              state_d = ST_HEAD;
            end else if (empty) begin
              wr0.valid = 1'b1;
              wr0.data  = s_axis_tdata;
              count_d   = CW'(count_q + CW'(1));
              state_d   = ST_HEAD;
            end else begin
              up_inj.valid = 1'b1;
              up_inj.value = s_axis_tdata;
              up_inj.off   = joff;
              count_d      = CW'(count_q + CW'(1));
              state_d      = ST_WAIT;
            end
          end else begin
            if (empty) begin
              rej_d   = 1'b1;
              state_d = ST_HEAD;
            end else if (count_q == CW'(1)) begin
              count_d = '0;
              state_d = ST_HEAD;
            end else begin
              fetch.valid = 1'b1;
              fetch.addr  = joff;
              flvl        = jl;
              count_d     = CW'(count_q - CW'(1));
              state_d     = ST_FETCH;
            end
          end
        end
      end
      ST_FETCH: begin
        dn_inj.valid = 1'b1;
        dn_inj.value = rd_w[lvl_q];
        state_d      = ST_WAIT;
      end
      ST_WAIT: begin
        if (|done_w) begin
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        fetch.valid = 1'b1;
        state_d     = ST_HEADW;
      end
      ST_HEADW: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    pqh_tok_t up_in, dn_in;
    pqh_wr_t  wdn_in, wup_in;
    pqh_rd_t  fr;

    if (k + 1 < LEVELS) begin : g_below
      assign up_in  = (up_inj.valid && ilvl == LW'(k)) ? up_inj : up_w[k+1];
      assign wup_in = wup_w[k+1];
    end else begin : g_last
      assign up_in  = (up_inj.valid && ilvl == LW'(k)) ? up_inj : '0;
      assign wup_in = '0;
    end

    if (k == 0) begin : g_root
      assign dn_in  = '0;
      assign wdn_in = wr0;
    end else begin : g_inner
      assign dn_in  = (k == 1) ? (dn_inj.valid ? dn_inj : dn_w[k-1]) : dn_w[k-1];
      assign wdn_in = wdn_w[k-1];
    end

    assign fr.valid = fetch.valid && (flvl == LW'(k));
    assign fr.addr  = fetch.addr;

    pqh_cell #(
      .K  (k),
      .CW (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .max_first_i (mf_q),
      .count_i     (count_q),
      .fetch_i     (fr),
      .rd_data_o   (rd_w[k]),
      .up_i        (up_in),
      .up_o        (up_w[k]),
      .dn_i        (dn_in),
      .dn_o        (dn_w[k]),
      .wr_dn_i     (wdn_in),
      .wr_up_i     (wup_in),
      .wr_dn_o     (wdn_w[k]),
      .wr_up_o     (wup_w[k]),
      .done_o      (done_w[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      mf_q        <= 1'b1;
      rej_q       <= 1'b0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rej_q   <= rej_d;
      lvl_q   <= lvl_d;
      if (cfg_we_i) begin
        mf_q <= cfg_wdata_i;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_HEADW) begin
      pend_q <= empty ? HEAD_EMPTY : rd_w[0];
    end
    if (state_q == ST_OUT && out_free) begin
      out_q <= {7'b0, rej_q, empty, 7'(count_q), pend_q};
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_one_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(done_w))
    else $error("more than one level cell finished at once");

  a_empty_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[39] |-> m_axis_tdata[31:0] == HEAD_EMPTY)
    else $error("empty result word without empty head");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !is_pop && full |=> count_q == $past(count_q))
    else $error("push into full queue changed the count");

  a_wait_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|done_w) |-> state_q == ST_WAIT)
    else $error("level cell finished outside a sift");

endmodule

// ===== hdl/pqh_cell.sv =====
// one heap level: local store, sift-up and sift-down step against neighbours
// depends on pqh_pkg
module pqh_cell import pqh_pkg::*; #(
  parameter int unsigned K  = 0,
  parameter int unsigned CW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          max_first_i,
  input  logic [CW-1:0] count_i,
  input  pqh_rd_t       fetch_i,
  output logic [VAL_W-1:0] rd_data_o,
  input  pqh_tok_t      up_i,
  output pqh_tok_t      up_o,
  input  pqh_tok_t      dn_i,
  output pqh_tok_t      dn_o,
  input  pqh_wr_t       wr_dn_i,
  input  pqh_wr_t       wr_up_i,
  output pqh_wr_t       wr_dn_o,
  output pqh_wr_t       wr_up_o,
  output logic          done_o
);

  localparam int unsigned AW    = (K == 0) ? 1 : K;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned IW    = OFF_W + 3;
  localparam logic [IW-1:0] BASE = IW'((1 << K) - 1);

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rd_a_q, rd_b_q;
  logic             act_q, act_d;
  logic             kind_q;
  pqh_tok_t         tok_q;

  logic [AW-1:0]    addr_a, addr_b;
  logic             we;
  logic [AW-1:0]    wa;
  logic [VAL_W-1:0] wd;

  logic [OFF_W-1:0] lpos_w, rpos_w, cpos_w;
  logic [OFF_W-1:0] ilpos_w;
  logic [IW-1:0]    li, ri, ci, gci, cnt;
  logic             up_above, take_l, take_r, moved;
  logic [VAL_W-1:0] best1, bestval;
  logic             self_we;
  logic [OFF_W-1:0] self_addr;

  assign rd_data_o = rd_a_q;
  assign act_d     = up_i.valid | dn_i.valid;
  assign ilpos_w   = dn_i.off << 1;

  always_comb begin
    if (fetch_i.valid) begin
      addr_a = fetch_i.addr[AW-1:0];
    end else if (up_i.valid) begin
      addr_a = AW'(up_i.off >> 1);
    end else begin
      addr_a = ilpos_w[AW-1:0];
    end
    addr_b = AW'(ilpos_w | OFF_W'(1));
  end

  always_comb begin
    lpos_w   = tok_q.off << 1;
    rpos_w   = lpos_w | OFF_W'(1);
    cnt      = IW'(count_i);
    li       = BASE + IW'(lpos_w);
    ri       = li + IW'(1);
    up_above = ranks_above(max_first_i, tok_q.value, rd_a_q);
    take_l   = (li < cnt) && ranks_above(max_first_i, rd_a_q, tok_q.value);
    best1    = take_l ? rd_a_q : tok_q.value;
    take_r   = (ri < cnt) && ranks_above(max_first_i, rd_b_q, best1);
    moved    = take_l | take_r;
    bestval  = take_r ? rd_b_q : best1;
    cpos_w   = take_r ? rpos_w : lpos_w;
    ci       = take_r ? ri : li;
    gci      = (ci << 1) + IW'(1);

    up_o      = '0;
    dn_o      = '0;
    wr_dn_o   = '0;
    wr_up_o   = '0;
    done_o    = 1'b0;
    self_we   = 1'b0;
    self_addr = '0;

    if (act_q && kind_q == TOK_UP) begin
      wr_dn_o.valid = 1'b1;
      wr_dn_o.addr  = tok_q.off;
      if (up_above) begin
        wr_dn_o.data = rd_a_q;
        if (K == 0) begin
          self_we = 1'b1;
          done_o  = 1'b1;
        end else begin
          up_o.valid = 1'b1;
          up_o.value = tok_q.value;
          up_o.off   = tok_q.off >> 1;
        end
      end else begin
        wr_dn_o.data = tok_q.value;
        done_o       = 1'b1;
      end
    end

    if (act_q && kind_q == TOK_DN) begin
      wr_up_o.valid = 1'b1;
      wr_up_o.addr  = tok_q.off;
      wr_up_o.data  = bestval;
      if (!moved) begin
        done_o = 1'b1;
      end else if (gci < cnt) begin
        dn_o.valid = 1'b1;
        dn_o.value = tok_q.value;
        dn_o.off   = cpos_w;
      end else begin
        self_we   = 1'b1;
        self_addr = cpos_w;
        done_o    = 1'b1;
      end
    end
  end

  always_comb begin
    we = 1'b1;
    wa = '0;
    wd = tok_q.value;
    if (self_we) begin
      wa = self_addr[AW-1:0];
    end else if (wr_dn_i.valid) begin
      wa = wr_dn_i.addr[AW-1:0];
      wd = wr_dn_i.data;
    end else if (wr_up_i.valid) begin
      wa = wr_up_i.addr[AW-1:0];
      wd = wr_up_i.data;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (up_i.valid) begin
      tok_q  <= up_i;
      kind_q <= TOK_UP;
    end else if (dn_i.valid) begin
      tok_q  <= dn_i;
      kind_q <= TOK_DN;
    end
  end

endmodule
